/* rtl/pnagc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pnagc_pkg;

	// Sample width default
	localparam int SampleBitsDef = 16;

	// Fixed datapath widths
	localparam int PowW  = 32;  // held and instantaneous power, Q2.30
	localparam int AccW  = 50;  // product and sum accumulator
	localparam int RootW = 32;  // sqrt(held) in Q1.31
	localparam int RemW  = 36;  // partial remainder of sqrt and divide
	localparam int DivW  = 44;  // dividend |x| * 2^(43-F) + s/2
	localparam int QuoW  = 17;  // quotient bits below the overflow check
	localparam int OutW  = 16;  // Q4.12 result part
	localparam int CntW  = 5;   // step counter for sqrt and divide
	localparam int WghtW = 16;
	localparam int FlrW  = 31;
	localparam int AddrW = 3;
	localparam int DataW = 32;

	localparam logic [WghtW-1:0] WeightRst = 16'd1311;
	localparam logic [FlrW-1:0]  FloorRst  = 31'd1;
	localparam logic [PowW-1:0]  HeldRst   = 32'h4000_0000;
	localparam logic [WghtW:0]   WeightOne = 17'h1_0000;
	localparam logic [QuoW-1:0]  PosLimit  = 17'd32767;
	localparam logic [QuoW-1:0]  NegLimit  = 17'd32768;

	typedef enum logic [0:0] {
		RegWeight = 1'b0,
		RegFloor  = 1'b1
	} reg_idx_t;

	typedef enum logic [12:0] {
		StIdle  = 13'b0_0000_0000_0001,
		StMulRe = 13'b0_0000_0000_0010,
		StMulIm = 13'b0_0000_0000_0100,
		StPwr   = 13'b0_0000_0000_1000,
		StMulW  = 13'b0_0000_0001_0000,
		StMulH  = 13'b0_0000_0010_0000,
		StAvg   = 13'b0_0000_0100_0000,
		StSqrt  = 13'b0_0000_1000_0000,
		StDLoad = 13'b0_0001_0000_0000,
		StDChk  = 13'b0_0010_0000_0000,
		StDiv   = 13'b0_0100_0000_0000,
		StDFin  = 13'b0_1000_0000_0000,
		StDone  = 13'b1_0000_0000_0000
	} state_t;

	typedef struct packed {
		state_t st;
		logic   part;  // 0: real part, 1: imaginary part
	} ctrl_t;

endpackage
`default_nettype wire

/* rtl/pnagc_csub.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared compare-subtract: one restoring step of sqrt or divide.
module pnagc_csub (
	input  wire logic [pnagc_pkg::RemW-1:0] a,
	input  wire logic [pnagc_pkg::RemW-1:0] b,
	output logic      [pnagc_pkg::RemW-1:0] diff,
	output logic                            ge
);
	logic [pnagc_pkg::RemW:0] d;

	assign d    = {1'b0, a} - {1'b0, b};
	assign diff = d[pnagc_pkg::RemW-1:0];
	assign ge   = ~d[pnagc_pkg::RemW];
endmodule
`default_nettype wire

/* rtl/pnagc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module pnagc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             out_free,
	output pnagc_pkg::ctrl_t      ctrl
);
	pnagc_pkg::state_t            state_q, state_d;
	logic                         part_q, part_d;
	logic [pnagc_pkg::CntW-1:0]   cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		part_d  = part_q;
		cnt_d   = cnt_q + 1'b1;
		unique case (state_q)
			pnagc_pkg::StIdle: begin
				part_d = 1'b0;
				if (start) state_d = pnagc_pkg::StMulRe;
			end
			pnagc_pkg::StMulRe: state_d = pnagc_pkg::StMulIm;
			pnagc_pkg::StMulIm: state_d = pnagc_pkg::StPwr;
			pnagc_pkg::StPwr:   state_d = pnagc_pkg::StMulW;
			pnagc_pkg::StMulW:  state_d = pnagc_pkg::StMulH;
			pnagc_pkg::StMulH:  state_d = pnagc_pkg::StAvg;
			pnagc_pkg::StAvg: begin
				state_d = pnagc_pkg::StSqrt;
				cnt_d   = '0;
			end
			pnagc_pkg::StSqrt: begin
				if (cnt_q == pnagc_pkg::CntW'(pnagc_pkg::RootW - 1))
					state_d = pnagc_pkg::StDLoad;
			end
			pnagc_pkg::StDLoad: state_d = pnagc_pkg::StDChk;
			pnagc_pkg::StDChk: begin
				state_d = pnagc_pkg::StDiv;
				cnt_d   = '0;
			end
			pnagc_pkg::StDiv: begin
				if (cnt_q == pnagc_pkg::CntW'(pnagc_pkg::QuoW - 1))
					state_d = pnagc_pkg::StDFin;
			end
			pnagc_pkg::StDFin: begin
				if (part_q) begin
					state_d = pnagc_pkg::StDone;
				end else begin
					part_d  = 1'b1;
					state_d = pnagc_pkg::StDLoad;
				end
			end
			pnagc_pkg::StDone: begin
				if (out_free) state_d = pnagc_pkg::StIdle;
			end
			default: state_d = pnagc_pkg::StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnagc_pkg::StIdle;
			part_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			part_q  <= part_d;
			cnt_q   <= cnt_d;
		end
	end

	assign ctrl.st   = state_q;
	assign ctrl.part = part_q;
endmodule
`default_nettype wire

/* rtl/pnagc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module pnagc_dp #(
	parameter int SAMPLE_BITS = pnagc_pkg::SampleBitsDef
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pnagc_pkg::ctrl_t                 ctrl,
	input  wire logic                             start,
	input  wire logic [SAMPLE_BITS-1:0]           in_real,
	input  wire logic [SAMPLE_BITS-1:0]           in_imag,
	input  wire logic [pnagc_pkg::WghtW-1:0]      weight,
	input  wire logic [pnagc_pkg::FlrW-1:0]       floor_val,
	output logic      [pnagc_pkg::OutW-1:0]       out_real,
	output logic      [pnagc_pkg::OutW-1:0]       out_imag,
	output logic                                  clipped
);
	localparam int SB    = SAMPLE_BITS;
	localparam int MulBW = (SB > pnagc_pkg::WghtW + 1) ? SB : pnagc_pkg::WghtW + 1;
	localparam int PwShr = (2 * SB >= 32) ? 2 * SB - 32 : 0;
	localparam int PwShl = (2 * SB < 32) ? 32 - 2 * SB : 0;
	localparam int DivSh = 44 - SB;
	localparam int PowW  = pnagc_pkg::PowW;
	localparam int AccW  = pnagc_pkg::AccW;
	localparam int RootW = pnagc_pkg::RootW;
	localparam int RemW  = pnagc_pkg::RemW;
	localparam int DivW  = pnagc_pkg::DivW;
	localparam int QuoW  = pnagc_pkg::QuoW;
	localparam int OutW  = pnagc_pkg::OutW;

	logic [SB-1:0]        mag_re_q, mag_im_q, mag_re_d, mag_im_d, mag_sel;
	logic                 neg_re_q, neg_im_q, neg_sel;
	logic [AccW-1:0]      prod_q, acc_q;
	logic [PowW-1:0]      pw_q, held_q;
	logic [PowW-1:0]      rad_q;
	logic [RemW-1:0]      rem_q;
	logic [RootW-1:0]     root_q;
	logic [DivW-1:0]      dvd_q;
	logic [QuoW-1:0]      quo_q;
	logic                 ovf_q;
	logic [OutW-1:0]      res_re_q, res_im_q;
	logic                 clip_q;

	logic [PowW-1:0]      mul_a;
	logic [MulBW-1:0]     mul_b;
	logic [PowW+MulBW-1:0] mul_p;
	logic [AccW-1:0]      sum, pw_full;
	logic [PowW-1:0]      pw_sat, avg_sat, floor_eff, avg_new;
	logic [AccW-17:0]     avg_full;
	logic [RemW-1:0]      cs_a, cs_b, cs_diff;
	logic                 cs_ge;
	logic [QuoW-1:0]      quo_lim, quo_sat;
	logic                 sat_hit;
	logic [OutW-1:0]      part_val;

	// Magnitudes of the incoming parts
	assign mag_re_d = in_real[SB-1] ? (~in_real) + {{(SB-1){1'b0}}, 1'b1} : in_real;
	assign mag_im_d = in_imag[SB-1] ? (~in_imag) + {{(SB-1){1'b0}}, 1'b1} : in_imag;

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.st)
			pnagc_pkg::StMulRe: begin
				mul_a = PowW'(mag_re_q);
				mul_b = MulBW'(mag_re_q);
			end
			pnagc_pkg::StMulIm: begin
				mul_a = PowW'(mag_im_q);
				mul_b = MulBW'(mag_im_q);
			end
			pnagc_pkg::StMulW: begin
				mul_a = pw_q;
				mul_b = MulBW'(weight);
			end
			pnagc_pkg::StMulH: begin
				mul_a = held_q;
				mul_b = MulBW'(pnagc_pkg::WeightOne - {1'b0, weight});
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Power scaled to Q2.30
	assign sum     = acc_q + prod_q;
	assign pw_full = (sum >> PwShr) << PwShl;
	assign pw_sat  = (|pw_full[AccW-1:PowW]) ? '1 : pw_full[PowW-1:0];

	// Rounded average, clamped and floored
	assign avg_full  = (AccW-16)'((sum + AccW'(32768)) >> 16);
	assign avg_sat   = (|avg_full[AccW-17:PowW]) ? '1 : avg_full[PowW-1:0];
	assign floor_eff = (floor_val == '0) ? PowW'(1) : {1'b0, floor_val};
	assign avg_new   = (avg_sat < floor_eff) ? floor_eff : avg_sat;

	// Compare-subtract operands
	always_comb begin
		cs_a = '0;
		cs_b = '0;
		case (ctrl.st)
			pnagc_pkg::StSqrt: begin
				cs_a = {rem_q[RemW-3:0], rad_q[PowW-1:PowW-2]};
				cs_b = RemW'({root_q, 2'b01});
			end
			pnagc_pkg::StDChk: begin
				cs_a = RemW'(dvd_q[DivW-1:QuoW]);
				cs_b = RemW'(root_q);
			end
			pnagc_pkg::StDiv: begin
				cs_a = {rem_q[RemW-2:0], dvd_q[QuoW-1]};
				cs_b = RemW'(root_q);
			end
			default: ;
		endcase
	end

	pnagc_csub u_csub (
		.a    (cs_a),
		.b    (cs_b),
		.diff (cs_diff),
		.ge   (cs_ge)
	);

	// Saturate the finished quotient
	assign mag_sel  = ctrl.part ? mag_im_q : mag_re_q;
	assign neg_sel  = ctrl.part ? neg_im_q : neg_re_q;
	assign quo_lim  = neg_sel ? pnagc_pkg::NegLimit : pnagc_pkg::PosLimit;
	assign sat_hit  = ovf_q || (quo_q > quo_lim);
	assign quo_sat  = sat_hit ? quo_lim : quo_q;
	assign part_val = neg_sel ? OutW'(-quo_sat) : OutW'(quo_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= pnagc_pkg::HeldRst;
		end else if (ctrl.st == pnagc_pkg::StAvg) begin
			held_q <= avg_new;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= AccW'(mul_p);
		if (start) begin
			mag_re_q <= mag_re_d;
			mag_im_q <= mag_im_d;
			neg_re_q <= in_real[SB-1];
			neg_im_q <= in_imag[SB-1];
		end
		case (ctrl.st)
			pnagc_pkg::StMulIm: acc_q <= prod_q;
			pnagc_pkg::StPwr:   pw_q  <= pw_sat;
			pnagc_pkg::StMulH:  acc_q <= prod_q;
			pnagc_pkg::StAvg: begin
				rad_q  <= avg_new;
				rem_q  <= '0;
				root_q <= '0;
			end
			pnagc_pkg::StSqrt: begin
				rad_q  <= rad_q << 2;
				rem_q  <= cs_ge ? cs_diff : cs_a;
				root_q <= {root_q[RootW-2:0], cs_ge};
			end
			pnagc_pkg::StDLoad: begin
				dvd_q <= (DivW'(mag_sel) << DivSh) + DivW'(root_q[RootW-1:1]);
			end
			pnagc_pkg::StDChk: begin
				ovf_q <= cs_ge;
				rem_q <= cs_a;
				quo_q <= '0;
			end
			pnagc_pkg::StDiv: begin
				dvd_q <= dvd_q << 1;
				rem_q <= cs_ge ? cs_diff : cs_a;
				quo_q <= {quo_q[QuoW-2:0], cs_ge};
			end
			pnagc_pkg::StDFin: begin
				if (ctrl.part) begin
					res_im_q <= part_val;
					clip_q   <= clip_q | sat_hit;
				end else begin
					res_re_q <= part_val;
					clip_q   <= sat_hit;
				end
			end
			default: ;
		endcase
	end

	assign out_real = res_re_q;
	assign out_imag = res_im_q;
	assign clipped  = clip_q;
endmodule
`default_nettype wire

/* rtl/power_normalizing_agc_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel    Dir  Handshake                 Payload
// s_axis     in   tvalid/tready             tdata: in_real, in_imag
// m_axis     out  tvalid/tready             tdata: out_real, out_imag; tuser: clipped
// apb        in   psel/penable/pready       paddr, pwdata, prdata (weight, floor)
//
// Each sample passes through the sequencer in order: an idle step, squaring and
// averaging on the shared multiplier, the square root and then one division per
// part on the one compare-subtract unit (one bit per cycle), and a final step
// that hands the result to the output register. Reset sets the sequencer, the
// configuration registers, the output valid flag and the held power (1.0 in Q2.30).
// A stalled result waits in the output register while the next sample starts;
// the sequencer holds in its final step only if that register is still full.
module power_normalizing_agc_core #(
	parameter int SAMPLE_BITS = pnagc_pkg::SampleBitsDef
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// in_real [SAMPLE_BITS-1:0], in_imag above it, zero padding to bytes
	input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// out_real [15:0], out_imag [31:16]
	output logic      [2*pnagc_pkg::OutW-1:0]          m_axis_tdata,
	// clipped [0]
	output logic                                       m_axis_tuser,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [pnagc_pkg::AddrW-1:0]           paddr,
	input  wire logic [pnagc_pkg::DataW-1:0]           pwdata,
	output logic      [pnagc_pkg::DataW-1:0]           prdata,
	output logic                                       pready
);
	pnagc_pkg::ctrl_t                 ctrl;
	logic                             start, out_free, out_load, cfg_wr;
	pnagc_pkg::reg_idx_t              reg_idx;
	logic [pnagc_pkg::WghtW-1:0]      weight_q;
	logic [pnagc_pkg::FlrW-1:0]       floor_q;
	logic [pnagc_pkg::OutW-1:0]       res_re, res_im;
	logic                             res_clip;
	logic                             m_valid_q;
	logic [2*pnagc_pkg::OutW-1:0]     m_data_q;
	logic                             m_user_q;

	// Configuration: word registers at byte addresses 0 and 4, no wait states
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = pnagc_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_idx)
			pnagc_pkg::RegWeight: prdata = pnagc_pkg::DataW'(weight_q);
			pnagc_pkg::RegFloor:  prdata = pnagc_pkg::DataW'(floor_q);
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= pnagc_pkg::WeightRst;
			floor_q  <= pnagc_pkg::FloorRst;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				pnagc_pkg::RegWeight: weight_q <= pwdata[pnagc_pkg::WghtW-1:0];
				pnagc_pkg::RegFloor:  floor_q  <= pwdata[pnagc_pkg::FlrW-1:0];
				default: ;
			endcase
		end
	end

	// Input side: take a sample only while the sequencer is idle
	assign s_axis_tready = (ctrl.st == pnagc_pkg::StIdle);
	assign start         = s_axis_tvalid & s_axis_tready;

	// Output side: the output register frees itself on a transfer
	assign out_free = ~m_valid_q | m_axis_tready;
	assign out_load = (ctrl.st == pnagc_pkg::StDone) & out_free;

	pnagc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	pnagc_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.start     (start),
		.in_real   (s_axis_tdata[SAMPLE_BITS-1:0]),
		.in_imag   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.weight    (weight_q),
		.floor_val (floor_q),
		.out_real  (res_re),
		.out_imag  (res_im),
		.clipped   (res_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Load the result payload with its flag
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {res_im, res_re};
			m_user_q <= res_clip;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
	// An accepted sample keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_axis_tready)
		else $error("sample accepted while previous one in flight");

	// A handed-off result shows up as valid on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid)
		else $error("result loaded but not presented");

	// A clip flag means at least one part sits at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
			(m_axis_tdata[15:0] == 16'h7FFF || m_axis_tdata[15:0] == 16'h8000 ||
			 m_axis_tdata[31:16] == 16'h7FFF || m_axis_tdata[31:16] == 16'h8000))
		else $error("clip flag without saturated part");
`endif
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import pnagc_pkg::*;

	localparam int SampleBits = SampleBitsDef;
	localparam int InDataW    = ((2 * SampleBits + 7) / 8) * 8;
	localparam int GainShift  = 43 - (SampleBits - 1);  // |x| in Q1.15 to Q4.12 over Q1.31 root
	localparam int IdlePct    = 12;                     // percent of idle cycles per side
	localparam int HoldoffAt  = 250;                    // result count that starts the long stall
	localparam int HoldoffLen = 600;                    // cycles of the long receiver stall
	localparam int StallLimit = 4000;                   // cycles with no transfer before giving up
	localparam int DrainWait  = 100;                    // settling wait before the final report

	typedef struct packed {
		logic [OutW-1:0] re;
		logic [OutW-1:0] im;
		logic            clip;
	} normalized_t;

	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// in_real [15:0], in_imag [31:16]
	logic [InDataW-1:0]   s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// out_real [15:0], out_imag [31:16]
	logic [2*OutW-1:0]    m_axis_tdata;
	// clipped [0]
	logic                 m_axis_tuser;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [AddrW-1:0]     paddr   = '0;
	logic [DataW-1:0]     pwdata  = '0;
	logic [DataW-1:0]     prdata;
	logic                 pready;

	// Samples waiting to be offered, and normalized results still owed by the block
	logic [InDataW-1:0]   pending_samples[$];
	normalized_t          expected_outputs[$];

	// Mirror of the register file and of the held average power
	logic [WghtW-1:0]     cfg_weight = WeightRst;
	logic [FlrW-1:0]      cfg_floor  = FloorRst;
	logic [PowW-1:0]      avg_power  = HeldRst;

	logic                 calm = 1'b0;   // no idling on either side while set
	int                   mismatches   = 0;
	int                   results_seen = 0;
	int                   holdoff_left = 0;
	int                   stall_cycles = 0;

	power_normalizing_agc_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #6 clk = ~clk;

	// Integer square root, one result bit per pass
	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] rest;
		logic [63:0] root;
		logic [63:0] probe;
		rest  = n;
		root  = '0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > rest)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// Scale one part by 1/root with rounding half away from zero; bit 16 flags saturation
	function automatic logic [16:0] apply_gain(input logic signed [15:0] x,
			input logic [63:0] root);
		logic [63:0] mag;
		logic [63:0] q;
		logic        sat;
		mag = 64'(x < 0 ? -32'(x) : 32'(x));
		q   = ((mag << GainShift) + (root >> 1)) / root;
		sat = 1'b0;
		if (x < 0) begin
			if (q > 64'(NegLimit)) begin
				q   = 64'(NegLimit);
				sat = 1'b1;
			end
			q = 64'd0 - q;
		end else if (q > 64'(PosLimit)) begin
			q   = 64'(PosLimit);
			sat = 1'b1;
		end
		return {sat, q[15:0]};
	endfunction

	// Advance the average power by one sample and return the normalized sample
	function automatic normalized_t normalize_sample(input logic [InDataW-1:0] word);
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [63:0]        ar;
		logic [63:0]        ai;
		logic [63:0]        pwr;
		logic [63:0]        avg;
		logic [63:0]        lim;
		logic [63:0]        root;
		logic [16:0]        sr;
		logic [16:0]        si;
		normalized_t        res;
		re  = word[SampleBits-1:0];
		im  = word[2*SampleBits-1:SampleBits];
		ar  = 64'(re < 0 ? -32'(re) : 32'(re));
		ai  = 64'(im < 0 ? -32'(im) : 32'(im));
		// Q1.15 squared is already Q2.30
		pwr = ar * ar + ai * ai;
		avg = (64'(cfg_weight) * pwr + (64'(WeightOne) - 64'(cfg_weight)) * 64'(avg_power)
			+ 64'h8000) >> 16;
		if (avg > 64'hFFFF_FFFF)
			avg = 64'hFFFF_FFFF;
		// a zero floor still keeps the average away from zero
		lim = (cfg_floor == '0) ? 64'd1 : 64'(cfg_floor);
		if (avg < lim)
			avg = lim;
		avg_power = avg[31:0];
		root = floor_sqrt(avg << 32);
		if (root == 0)
			root = 64'd1;
		sr = apply_gain(re, root);
		si = apply_gain(im, root);
		res.re   = sr[15:0];
		res.im   = si[15:0];
		res.clip = sr[16] | si[16];
		return res;
	endfunction

	// Sender: hold an offered sample until the transfer, then pull the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			avg_power = HeldRst;
		end else begin : drive
			logic taken;
			taken = s_axis_tvalid && s_axis_tready;
			if (taken)
				expected_outputs.push_back(normalize_sample(s_axis_tdata));
			if (s_axis_tvalid && !taken) begin
				// hold the current sample
			end else if (pending_samples.size() != 0
					&& (calm || $urandom_range(99) >= IdlePct)) begin
				s_axis_tdata  <= pending_samples.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata  <= InDataW'($urandom());
			end
		end
	end

	// Receiver: check each result against the oldest expectation, then pick the next ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			holdoff_left = 0;
		end else begin : collect
			normalized_t want;
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_outputs.size() == 0) begin
					$error("result transfer with nothing expected: data %h clipped %b",
						m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					want = expected_outputs.pop_front();
					if (m_axis_tdata[15:0] !== want.re) begin
						$error("out_real: expected %0d, actual %0d",
							$signed(want.re), $signed(m_axis_tdata[15:0]));
						mismatches++;
					end
					if (m_axis_tdata[31:16] !== want.im) begin
						$error("out_imag: expected %0d, actual %0d",
							$signed(want.im), $signed(m_axis_tdata[31:16]));
						mismatches++;
					end
					if (m_axis_tuser !== want.clip) begin
						$error("clipped: expected %0d, actual %0d", want.clip, m_axis_tuser);
						mismatches++;
					end
				end
				// Start one long stall so the block backs up into its input
				if (results_seen == HoldoffAt)
					holdoff_left = HoldoffLen;
			end
			if (holdoff_left != 0) begin
				holdoff_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || $urandom_range(99) >= IdlePct;
			end
		end
	end

	// Give up once nothing has moved on any port for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pwrite))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// APB write: setup cycle, then access cycle; the register takes the value on the access edge
	task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == RegWeight)
			cfg_weight = value[WghtW-1:0];
		else
			cfg_floor = value[FlrW-1:0];
	endtask

	// Wait until every sample is taken and every result has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0);
	endtask

	function automatic logic [15:0] rand_part();
		int m;
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 16'($urandom());
			10, 11, 12, 13: begin
				m = 300;
				return 16'($urandom_range(2 * m) - m);
			end
			14, 15, 16: begin
				case ($urandom_range(4))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'h0001;
					3:       return 16'hFFFF;
					default: return 16'h0000;
				endcase
			end
			17, 18: return 16'h0000;
			default: begin
				m = 10;
				return 16'($urandom_range(2 * m) - m);
			end
		endcase
	endfunction

	task automatic queue_random(input int count);
		logic [15:0] re;
		logic [15:0] im;
		for (int i = 0; i < count; i++) begin
			re = rand_part();
			// runs of silence pull the average down so later samples get large gain
			im = (re == 16'h0000 && $urandom_range(1) == 0) ? 16'h0000 : rand_part();
			pending_samples.push_back({im, re});
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: extremes of both parts, sign mixes, alternating bits, silence
		pending_samples.push_back({16'h0000, 16'h0000});
		pending_samples.push_back({16'h7FFF, 16'h7FFF});
		pending_samples.push_back({16'h8000, 16'h8000});
		pending_samples.push_back({16'h7FFF, 16'h8000});
		pending_samples.push_back({16'h8000, 16'h7FFF});
		pending_samples.push_back({16'h0001, 16'hFFFF});
		pending_samples.push_back({16'hFFFF, 16'h0000});
		pending_samples.push_back({16'h5555, 16'hAAAA});
		pending_samples.push_back({16'hAAAA, 16'h5555});
		pending_samples.push_back({16'h0000, 16'h8000});
		pending_samples.push_back({16'h8000, 16'h0000});
		repeat (4) pending_samples.push_back({16'h0000, 16'h0000});
		pending_samples.push_back({16'h0000, 16'h7FFF});
		queue_random(150);
		wait_drained();

		// Largest weight on the new sample, zero floor: the average nearly tracks each sample
		write_reg(RegWeight, 32'd65535);
		write_reg(RegFloor, 32'd0);
		pending_samples.push_back({16'h7FFF, 16'h8000});
		repeat (3) pending_samples.push_back({16'h0000, 16'h0000});
		pending_samples.push_back({16'h0000, 16'h0001});
		pending_samples.push_back({16'h8000, 16'h8000});
		queue_random(150);
		// leave the average at its smallest for the next settings
		repeat (3) pending_samples.push_back({16'h0000, 16'h0000});
		wait_drained();

		// Zero weight freezes the tiny average: large gain, saturation on almost everything
		write_reg(RegWeight, 32'd0);
		write_reg(RegFloor, 32'd0);
		pending_samples.push_back({16'h0007, 16'hFFF8});
		pending_samples.push_back({16'h0008, 16'hFFF7});
		pending_samples.push_back({16'h8000, 16'h7FFF});
		pending_samples.push_back({16'h0000, 16'h0000});
		queue_random(100);
		wait_drained();

		// Default weight, floor at 1.0
		write_reg(RegWeight, 32'(WeightRst));
		write_reg(RegFloor, 32'h4000_0000);
		queue_random(150);
		wait_drained();

		// Smallest nonzero weight, largest floor the field holds
		write_reg(RegWeight, 32'd1);
		write_reg(RegFloor, 32'h7FFF_FFFF);
		queue_random(100);
		wait_drained();

		// Random weight, low random floor
		write_reg(RegWeight, 32'($urandom_range(65535)));
		write_reg(RegFloor, 32'($urandom_range(1, 1 << 20)));
		queue_random(200);
		wait_drained();

		// Back to reset values; run with no idling on either side
		write_reg(RegWeight, 32'(WeightRst));
		write_reg(RegFloor, 32'(FloorRst));
		calm = 1'b1;
		queue_random(150);
		wait_drained();
		calm = 1'b0;

		repeat (DrainWait) @(posedge clk);
		if (mismatches == 0 && expected_outputs.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* power_normalizing_agc_core.f */
rtl/pnagc_pkg.sv
rtl/pnagc_csub.sv
rtl/pnagc_ctrl.sv
rtl/pnagc_dp.sv
rtl/power_normalizing_agc_core.sv
tb/tb_top.sv
